/* src/rdit_pkg.sv */
`default_nettype none
package rdit_pkg;

	// register indexes on the configuration port
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DELAY    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FOREVER  = 2'd3;

	// field widths fixed by the interface
	localparam int VAL_BITS   = 32;
	localparam int FIRES_BITS = 33;

	localparam logic [VAL_BITS-1:0]   MAX32     = {VAL_BITS{1'b1}};
	localparam logic [FIRES_BITS-1:0] FIRES_MAX = {FIRES_BITS{1'b1}};

	typedef struct packed {
		logic                mode;
		logic [VAL_BITS-1:0] elapsed;
	} in_word_t;

	typedef struct packed {
		logic                delay_fired;
		logic [VAL_BITS-1:0] fire_count;
		logic [VAL_BITS-1:0] fire_period;
		logic                finished;
	} out_word_t;

endpackage
`default_nettype wire

/* src/repeating_delay_interval_timer_unit.sv */
`default_nettype none
// Path of a word: a tick that fires on a nonzero interval goes through delay check, prep,
// divide, limit, fire count and push, with a serial multiply of 32 steps added when the fire
// count is cut or clipped; re-arm, stopped and first ticks go straight to push.
// One word at a time: a new word is taken only when idle; the bit-serial divider (TIME_BITS steps) sets the rate.
// Reset (arst_n low, asynchronous): control and configuration registers zero, timer stopped, output word empty.
module repeating_delay_interval_timer_unit import rdit_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire in_word_t                in_data,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output out_word_t                    out_data,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [VAL_BITS-1:0]     cfg_data
);

	localparam int W = TIME_BITS;
	localparam int MUL_STEPS = VAL_BITS;
	localparam int MCNT_BITS = $clog2(MUL_STEPS + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DELAY = 4'd1;
	localparam logic [3:0] ST_PREP  = 4'd2;
	localparam logic [3:0] ST_DIV   = 4'd3;
	localparam logic [3:0] ST_LIMIT = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_SUB   = 4'd6;
	localparam logic [3:0] ST_FIRES = 4'd7;
	localparam logic [3:0] ST_PUSH  = 4'd8;

	logic [3:0]            state_q;
	logic [VAL_BITS-1:0]   interval_q;
	logic [VAL_BITS-1:0]   delay_q;
	logic [VAL_BITS-1:0]   repeat_q;
	logic                  forever_q;
	logic [W-1:0]          acc_q;
	logic [FIRES_BITS-1:0] fires_q;
	logic                  first_q;
	logic                  dpend_q;
	logic                  stopped_q;
	logic                  out_valid_q;
	out_word_t             out_q;
	logic [VAL_BITS-1:0]   n_q;
	logic [VAL_BITS-1:0]   period_q;
	logic                  exact_q;
	logic                  dfired_q;
	logic                  fin_q;
	logic [W-1:0]          prod_q;
	logic [VAL_BITS-1:0]   m_q;
	logic [MCNT_BITS-1:0]  mcnt_q;

	logic                  accept;
	logic                  push_ok;
	logic [W+VAL_BITS:0]   sum_ext;
	logic [W-1:0]          sum_sat;
	logic [W+VAL_BITS-1:0] acc_ext;
	logic [W+VAL_BITS-1:0] dly_ext;
	logic [W+VAL_BITS-1:0] ivl_ext;
	logic [W+VAL_BITS-1:0] rem_ext;
	logic [W+VAL_BITS-1:0] dly_diff;
	logic                  dly_reached;
	logic [VAL_BITS-1:0]   acc_sat32;
	logic [FIRES_BITS-1:0] fires_inc;
	logic [W-1:0]          ivl_w;
	logic                  div_start;
	logic                  div_done;
	logic [W-1:0]          div_quot;
	logic [VAL_BITS-1:0]   div_rem;
	logic [W+VAL_BITS-1:0] quot_ext;
	logic [FIRES_BITS-1:0] rep_ext;
	logic [FIRES_BITS-1:0] left;
	logic                  cut;
	logic [VAL_BITS-1:0]   n_fin;
	logic                  need_mul;
	logic [FIRES_BITS:0]   fires_sum;

	assign accept    = in_valid && !in_stall;
	assign push_ok   = !out_valid_q || !out_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// saturating accumulate, delay compare and narrowing of time values
	always_comb begin
		sum_ext     = {{(VAL_BITS + 1){1'b0}}, acc_q}
		            + {{(W + 1){1'b0}}, in_data.elapsed};
		sum_sat     = (|sum_ext[W+VAL_BITS:W]) ? {W{1'b1}} : sum_ext[W-1:0];
		acc_ext     = {{VAL_BITS{1'b0}}, acc_q};
		dly_ext     = {{W{1'b0}}, delay_q};
		ivl_ext     = {{W{1'b0}}, interval_q};
		rem_ext     = {{W{1'b0}}, div_rem};
		ivl_w       = ivl_ext[W-1:0];
		dly_diff    = acc_ext - dly_ext;
		dly_reached = acc_ext >= dly_ext;
		acc_sat32   = (|acc_ext[W+VAL_BITS-1:VAL_BITS]) ? MAX32 : acc_ext[VAL_BITS-1:0];
		fires_inc   = (fires_q == FIRES_MAX) ? FIRES_MAX : fires_q + 1'b1;
		quot_ext    = {{VAL_BITS{1'b0}}, div_quot};
	end

	// cut the fire count to what the repeat limit leaves
	always_comb begin
		rep_ext  = {1'b0, repeat_q};
		left     = (fires_q <= rep_ext) ? rep_ext + 1'b1 - fires_q : FIRES_BITS'(1);
		cut      = !forever_q && (n_q != '0) && ({1'b0, n_q} >= left);
		n_fin    = cut ? left[VAL_BITS-1:0] : n_q;
		need_mul = (interval_q != '0) && (cut || !exact_q);
		fires_sum = {1'b0, fires_q} + {2'b00, n_q};
	end

	assign div_start = state_q == ST_PREP && interval_q != '0;

	rdit_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (interval_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= '0;
			delay_q    <= '0;
			repeat_q   <= '0;
			forever_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INTERVAL: interval_q <= cfg_data;
				REG_DELAY:    delay_q    <= cfg_data;
				REG_REPEAT:   repeat_q   <= cfg_data;
				REG_FOREVER:  forever_q  <= cfg_data[0];
			endcase
		end
	end

	// sequencer and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			fires_q     <= '0;
			first_q     <= 1'b0;
			dpend_q     <= 1'b0;
			stopped_q   <= 1'b1;
			out_valid_q <= 1'b0;
			mcnt_q      <= '0;
		end else begin
			// load the output word or drop it once taken
			if (state_q == ST_PUSH && push_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PUSH;
						if (in_data.mode) begin
							acc_q     <= '0;
							fires_q   <= '0;
							first_q   <= 1'b1;
							dpend_q   <= delay_q != '0;
							stopped_q <= 1'b0;
						end else if (!stopped_q && first_q) begin
							first_q <= 1'b0;
							acc_q   <= '0;
							fires_q <= '0;
						end else if (!stopped_q) begin
							acc_q   <= sum_sat;
							state_q <= ST_DELAY;
						end
					end
				end
				ST_DELAY: begin
					if (!dpend_q) begin
						state_q <= ST_PREP;
					end else if (!dly_reached) begin
						state_q <= ST_PUSH;
					end else begin
						acc_q   <= dly_diff[W-1:0];
						fires_q <= fires_inc;
						dpend_q <= 1'b0;
						if (!forever_q && fires_inc > rep_ext) begin
							stopped_q <= 1'b1;
							state_q   <= ST_PUSH;
						end else begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					if (interval_q == '0) begin
						acc_q   <= '0;
						state_q <= ST_LIMIT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_LIMIT;
					end
				end
				ST_LIMIT: begin
					if (cut) begin
						stopped_q <= 1'b1;
					end
					if (need_mul) begin
						mcnt_q  <= MCNT_BITS'(MUL_STEPS);
						state_q <= ST_MUL;
					end else begin
						if (interval_q != '0) begin
							acc_q <= rem_ext[W-1:0];
						end
						state_q <= ST_FIRES;
					end
				end
				ST_MUL: begin
					mcnt_q <= mcnt_q - 1'b1;
					if (mcnt_q == MCNT_BITS'(1)) begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					acc_q   <= acc_q - prod_q;
					state_q <= ST_FIRES;
				end
				ST_FIRES: begin
					fires_q <= fires_sum[FIRES_BITS] ? FIRES_MAX : fires_sum[FIRES_BITS-1:0];
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (push_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result fields and serial multiply datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					n_q      <= '0;
					period_q <= '0;
					exact_q  <= 1'b1;
					dfired_q <= 1'b0;
					fin_q    <= 1'b0;
				end
			end
			ST_DELAY: begin
				if (dpend_q && dly_reached) begin
					dfired_q <= 1'b1;
					fin_q    <= !forever_q && fires_inc > rep_ext;
				end
			end
			ST_PREP: begin
				if (interval_q == '0) begin
					n_q      <= VAL_BITS'(1);
					period_q <= acc_sat32;
					exact_q  <= 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					n_q      <= (|quot_ext[W+VAL_BITS-1:VAL_BITS]) ? MAX32
					            : quot_ext[VAL_BITS-1:0];
					exact_q  <= !(|quot_ext[W+VAL_BITS-1:VAL_BITS]);
					period_q <= interval_q;
				end
			end
			ST_LIMIT: begin
				n_q    <= n_fin;
				fin_q  <= fin_q || cut;
				m_q    <= n_fin;
				prod_q <= '0;
			end
			ST_MUL: begin
				prod_q <= {prod_q[W-2:0], 1'b0} + (m_q[VAL_BITS-1] ? ivl_w : '0);
				m_q    <= {m_q[VAL_BITS-2:0], 1'b0};
			end
			ST_PUSH: begin
				if (push_ok) begin
					out_q.delay_fired <= dfired_q;
					out_q.fire_count  <= n_q;
					out_q.fire_period <= (n_q != '0) ? period_q : '0;
					out_q.finished    <= fin_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");
	a_push_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH && !(out_valid_q && out_stall)) |=>
		(out_valid_q && state_q == ST_IDLE))
		else $error("result word not loaded when output was free");
	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.fire_count == '0) |-> out_q.fire_period == '0)
		else $error("period reported without fires");

endmodule
`default_nettype wire

/* src/rdit_div.sv */
`default_nettype none
module rdit_div import rdit_pkg::*; #(
	parameter int W = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [W-1:0]        dividend,
	input  wire logic [VAL_BITS-1:0] divisor,
	output logic                     done,
	output logic [W-1:0]             quot,
	output logic [VAL_BITS-1:0]      rem
);

	localparam int CNT_BITS = $clog2(W + 1);

	logic                  run_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [W-1:0]          d_q;
	logic [VAL_BITS-1:0]   r_q;
	logic [VAL_BITS-1:0]   dv_q;
	logic [VAL_BITS:0]     partial;
	logic [VAL_BITS:0]     diff;
	logic                  ge;

	// one restoring step: shift a dividend bit into the partial remainder
	always_comb begin
		partial = {r_q, d_q[W-1]};
		diff    = partial - {1'b0, dv_q};
		ge      = partial >= {1'b0, dv_q};
	end

	// sequence the steps, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_BITS'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift dividend out and quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			d_q  <= dividend;
			r_q  <= '0;
			dv_q <= divisor;
		end else if (run_q) begin
			d_q <= {d_q[W-2:0], ge};
			r_q <= ge ? diff[VAL_BITS-1:0] : partial[VAL_BITS-1:0];
		end
	end

	assign done = done_q;
	assign quot = d_q;
	assign rem  = r_q;

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q))
		else $error("divider done without a running pass");
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> cnt_q != '0)
		else $error("divider running with an empty step count");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> r_q < dv_q)
		else $error("divider remainder not below divisor");

endmodule
`default_nettype wire
